// File: hw/rtl/lmsf_pkg.sv
// lmsf_pkg: shared types and constants for the serpentine led frame builder
// no dependencies; imported by lmsf_ctrl, lmsf_datapath and the top level
`default_nettype none

package lmsf_pkg;

   // request actions
   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_READ    = 2'd1;
   localparam logic [1:0] ACT_FILL    = 2'd2;
   localparam logic [1:0] ACT_DISPLAY = 2'd3;

   // kind of result carried through the read stage
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_REPLY = 2'd3;

   localparam int COL_W   = 3;  // covers up to 8 columns
   localparam int ROW_W   = 3;  // covers up to 8 rows
   localparam int IDX_W   = 6;  // row * columns + column, at most 55
   localparam int COLOR_W = 24;
   localparam int WORD_W  = 32;

   localparam logic [7:0]        PIXEL_HEAD = 8'hFF;
   localparam logic [WORD_W-1:0] START_WORD = 32'h0000_0000;
   localparam logic [WORD_W-1:0] END_WORD   = 32'hFF00_0000;

   // color packed as {red, green, blue}
   typedef logic [COLOR_W-1:0] color_type;

   // controller to datapath
   typedef struct packed {
      logic             wr_en;
      logic             fill_en;
      logic             issue;
      logic [1:0]       kind;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      color_type        color;
   } lmsf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic issue_ok;
   } lmsf_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/lmsf_ctrl.sv
// lmsf_ctrl: request sequencer, walks the display frame in serpentine order
// depends on lmsf_pkg
`default_nettype none

module lmsf_ctrl #(
   parameter int COLUMNS = 8,
   parameter int ROWS    = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_action,
   input  wire logic [2:0]               req_column,
   input  wire logic [1:0]               req_row,
   input  wire lmsf_pkg::color_type      req_color,
   input  wire lmsf_pkg::lmsf_status_type status,
   output lmsf_pkg::lmsf_cmd_type        cmd
);
   import lmsf_pkg::*;

   localparam int END_WORDS = 1 + (COLUMNS * ROWS) / 64;
   localparam int ECW       = (END_WORDS > 1) ? $clog2(END_WORDS) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PIX  = 2'd1;
   localparam logic [1:0] ST_END  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ECW-1:0]   end_ff, end_in;
   logic             needs_issue;
   logic             accept;
   logic             end_last;

   assign needs_issue = (req_action == ACT_READ) || (req_action == ACT_DISPLAY);
   assign req_stall   = (state_ff != ST_IDLE) || (needs_issue && !status.issue_ok);
   assign accept      = req_valid && !req_stall;
   assign end_last    = (end_ff == ECW'(END_WORDS - 1));

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      end_in       = end_ff;
      cmd          = '0;
      cmd.color    = req_color;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_WRITE: begin
                     cmd.wr_en = 1'b1;
                     cmd.row   = {1'b0, req_row};
                     cmd.col   = req_column;
                  end
                  ACT_READ: begin
                     cmd.issue = 1'b1;
                     cmd.kind  = KIND_REPLY;
                     cmd.last  = 1'b1;
                     cmd.row   = {1'b0, req_row};
                     cmd.col   = req_column;
                  end
                  ACT_FILL: begin
                     cmd.fill_en = 1'b1;
                  end
                  default: begin
                     cmd.issue = 1'b1;
                     cmd.kind  = KIND_START;
                     col_in    = '0;
                     row_in    = '0;
                     state_in  = ST_PIX;
                  end
               endcase
            end
         end
         ST_PIX: begin
            if (status.issue_ok) begin
               cmd.issue = 1'b1;
               cmd.kind  = KIND_PIXEL;
               cmd.row   = row_ff;
               // odd rows run right to left
               cmd.col   = row_ff[0] ? (COL_W'(COLUMNS - 1) - col_ff) : col_ff;
               if (col_ff == COL_W'(COLUMNS - 1)) begin
                  col_in = '0;
                  if (row_ff == ROW_W'(ROWS - 1)) begin
                     end_in   = '0;
                     state_in = ST_END;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_END: begin
            if (status.issue_ok) begin
               cmd.issue = 1'b1;
               cmd.kind  = KIND_END;
               cmd.last  = end_last;
               if (end_last) begin
                  state_in = ST_IDLE;
               end else begin
                  end_in = end_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      col_ff <= col_in;
      row_ff <= row_in;
      end_ff <= end_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/lmsf_datapath.sv
// lmsf_datapath: pixel memory with valid bits, read stage and result register
// depends on lmsf_pkg
`default_nettype none

module lmsf_datapath #(
   parameter int COLUMNS = 8,
   parameter int ROWS    = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lmsf_pkg::lmsf_cmd_type cmd,
   output lmsf_pkg::lmsf_status_type   status,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [31:0]                 rsp_frame_word,
   output logic [7:0]                  rsp_red_out,
   output logic [7:0]                  rsp_green_out,
   output logic [7:0]                  rsp_blue_out,
   output logic                        rsp_is_read_reply,
   output logic                        rsp_last
);
   import lmsf_pkg::*;

   localparam int DEPTH = COLUMNS * ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   color_type        mem [DEPTH];
   logic [DEPTH-1:0] valid_ff, valid_in;
   color_type        fill_ff, fill_in;

   logic             s1_vld_ff, s1_vld_in;
   logic [1:0]       s1_kind_ff;
   logic             s1_last_ff;
   logic             s1_hit_ff;
   color_type        s1_alt_ff;
   color_type        s1_rdata_ff;

   logic             out_vld_ff, out_vld_in;
   logic [31:0]      out_word_ff;
   color_type        out_rgb_ff;
   logic             out_reply_ff;
   logic             out_last_ff;

   logic [IDX_W-1:0] idx;
   logic [AW-1:0]    addr;
   logic             in_range;
   logic             out_free;
   logic             load_out;
   color_type        s1_color;

   assign idx      = IDX_W'(cmd.row) * IDX_W'(COLUMNS) + IDX_W'(cmd.col);
   assign addr     = idx[AW-1:0];
   assign in_range = ({1'b0, cmd.col} < 4'(COLUMNS)) && ({1'b0, cmd.row} < 4'(ROWS));

   assign out_free        = !out_vld_ff || !rsp_stall;
   assign load_out        = s1_vld_ff && out_free;
   assign status.issue_ok = !s1_vld_ff || out_free;

   // entries never written since reset or the last fill read as the fill color
   assign s1_color = s1_hit_ff ? s1_rdata_ff : s1_alt_ff;

   always_comb begin
      valid_in = valid_ff;
      fill_in  = fill_ff;
      if (cmd.fill_en) begin
         valid_in = '0;
         fill_in  = cmd.color;
      end else if (cmd.wr_en && in_range) begin
         valid_in[addr] = 1'b1;
      end
      s1_vld_in  = cmd.issue ? 1'b1 : (load_out ? 1'b0 : s1_vld_ff);
      out_vld_in = load_out ? 1'b1 : (out_free ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         fill_ff    <= '0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         fill_ff    <= fill_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // pixel memory, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en && in_range) begin
         mem[addr] <= cmd.color;
      end
      if (cmd.issue) begin
         s1_rdata_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_kind_ff <= cmd.kind;
         s1_last_ff <= cmd.last;
         s1_hit_ff  <= in_range && valid_ff[addr];
         s1_alt_ff  <= in_range ? fill_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_last_ff <= s1_last_ff;
         case (s1_kind_ff)
            KIND_START: begin
               out_word_ff  <= START_WORD;
               out_rgb_ff   <= '0;
               out_reply_ff <= 1'b0;
            end
            KIND_PIXEL: begin
               out_word_ff  <= {PIXEL_HEAD, s1_color[7:0], s1_color[15:8], s1_color[23:16]};
               out_rgb_ff   <= '0;
               out_reply_ff <= 1'b0;
            end
            KIND_END: begin
               out_word_ff  <= END_WORD;
               out_rgb_ff   <= '0;
               out_reply_ff <= 1'b0;
            end
            default: begin
               out_word_ff  <= '0;
               out_rgb_ff   <= s1_color;
               out_reply_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_frame_word    = out_word_ff;
   assign rsp_red_out       = out_rgb_ff[23:16];
   assign rsp_green_out     = out_rgb_ff[15:8];
   assign rsp_blue_out      = out_rgb_ff[7:0];
   assign rsp_is_read_reply = out_reply_ff;
   assign rsp_last          = out_last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/led_matrix_serpentine_framer.sv
// led_matrix_serpentine_framer: pixel store and strip frame builder for an led matrix
// a read reply or the first display word passes the read stage, then the result register
// write and fill leave the sequencer idle; a display sends a start word, N pixel words and
// 1 + N/64 end words (N = COLUMNS * ROWS), one a cycle unless stalled (one memory read port)
// reset: synchronous; clears the valid bits and fill color at once so every pixel reads black
// depends on lmsf_pkg, lmsf_ctrl, lmsf_datapath
`default_nettype none

module led_matrix_serpentine_framer #(
   parameter int COLUMNS = 8,   // 1 to 8
   parameter int ROWS    = 4    // 1 to 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [2:0]  req_column,
   input  wire logic [1:0]  req_row,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_frame_word,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic             rsp_is_read_reply,
   output logic             rsp_last
);
   import lmsf_pkg::*;

   lmsf_cmd_type    cmd;
   lmsf_status_type status;
   color_type       req_color;

   // color travels as {red, green, blue}
   assign req_color = {req_red_in, req_green_in, req_blue_in};

   // sequencer: takes a request; for a display it walks start word, pixels, end words
   lmsf_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_column (req_column),
      .req_row    (req_row),
      .req_color  (req_color),
      .status     (status),
      .cmd        (cmd)
   );

   // memory, read stage and result register; a finished result waits there,
   // and the sequencer stalls once the read stage also holds a result
   lmsf_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_word    (rsp_frame_word),
      .rsp_red_out       (rsp_red_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_is_read_reply (rsp_is_read_reply),
      .rsp_last          (rsp_last)
   );

`ifndef SYNTH
   // the read stage is never overwritten while it still holds a result
   a_issue_room: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> status.issue_ok)
      else $error("issue into a full read stage");

   // one action per cycle toward the datapath
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.wr_en, cmd.fill_en, cmd.issue}) <= 1)
      else $error("more than one datapath command at once");

   // a read reply is a run of its own and carries no frame word
   a_reply_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_read_reply |-> rsp_last && (rsp_frame_word == 32'h0))
      else $error("malformed read reply");

   // a display word never carries pixel color in the reply fields
   a_word_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_read_reply |->
         (rsp_red_out == 8'h0) && (rsp_green_out == 8'h0) && (rsp_blue_out == 8'h0))
      else $error("display word with reply color");
`endif

endmodule

`default_nettype wire
